>>> hdl/ddow_pkg.sv
// Shared constants for the differential-drive odometry and command watchdog.
// Holds the CORDIC arctangent table and the fixed-point scale factors.
// No dependencies.
package ddow_pkg;

	// Start vector of the rotation: the CORDIC gain in Q2.30.
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	// Heading scale: round(2^40 / (2*pi*10^6)).
	localparam logic [23:0] YAW_SCALE = 24'd174993;
	// Microseconds in one second, and half of it for rounding.
	localparam logic [20:0] US_PER_S = 21'd1000000;
	localparam logic [47:0] US_HALF = 48'd500000;
	localparam logic [23:0] TIMEOUT_RESET = 24'd500000;
	// Iterations of the serial multiplier and divider.
	localparam int MUL_BITS = 24;
	localparam int DIV_BITS = 48;

	// Arctangent of 2^-i in binary-angle units.
	function automatic logic [32:0] atan_at(input logic [4:0] i);
		logic [32:0] v;
		begin
			case (i)
				5'd0: v = 33'd536870912;
				5'd1: v = 33'd316933406;
				5'd2: v = 33'd167458907;
				5'd3: v = 33'd85004756;
				5'd4: v = 33'd42667331;
				5'd5: v = 33'd21354465;
				5'd6: v = 33'd10679838;
				5'd7: v = 33'd5340245;
				5'd8: v = 33'd2670163;
				5'd9: v = 33'd1335087;
				5'd10: v = 33'd667544;
				5'd11: v = 33'd333772;
				5'd12: v = 33'd166886;
				5'd13: v = 33'd83443;
				5'd14: v = 33'd41722;
				5'd15: v = 33'd20861;
				5'd16: v = 33'd10430;
				5'd17: v = 33'd5215;
				5'd18: v = 33'd2608;
				5'd19: v = 33'd1304;
				5'd20: v = 33'd652;
				5'd21: v = 33'd326;
				5'd22: v = 33'd163;
				5'd23: v = 33'd81;
				5'd24: v = 33'd41;
				5'd25: v = 33'd20;
				5'd26: v = 33'd10;
				5'd27: v = 33'd5;
				5'd28: v = 33'd3;
				5'd29: v = 33'd1;
				5'd30: v = 33'd1;
				default: v = 33'd0;
			endcase
			return v;
		end
	endfunction

endpackage

>>> hdl/diff_drive_odometry_watchdog_core.sv
// Dead-reckoning odometry for a differential-drive base, with a command watchdog.
// A velocity command is taken and gives no result. A tick runs the CORDIC (one
// iteration a cycle), then a shared bit-serial multiplier (six products) and a
// bit-serial divider by one million (twice) before its pose is offered. One item
// is worked on at a time; the next is taken once the pose has been handed to the
// output register. Depends on ddow_pkg.
module diff_drive_odometry_watchdog_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic signed [23:0] linear_speed,
	input  logic signed [23:0] angular_speed,
	input  logic [19:0] elapsed_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0] heading,
	output logic signed [23:0] speed_now,
	output logic signed [23:0] turn_now,
	output logic        stopped
);
	import ddow_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_QUAD, S_MUL, S_DIV, S_OUT} state_t;
	typedef enum logic [2:0] {PH_XT, PH_XD, PH_YT, PH_YD, PH_H1, PH_H2} phase_t;

	localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

	state_t state_q;
	phase_t phase_q;
	logic [5:0] cnt_q;
	logic [23:0] timeout_q;
	logic signed [31:0] x_pos_q, y_pos_q;
	logic [31:0] yaw_q;
	logic signed [23:0] lin_q, ang_q;
	logic [23:0] age_q;
	logic timed_q;
	logic [19:0] el_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic signed [33:0] cos_q, sin_q;
	logic [71:0] mp_q;
	logic [47:0] ma_q;
	logic neg_q;
	logic [47:0] dn_q;
	logic [20:0] rem_q;
	logic out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0] heading_q;
	logic signed [23:0] speed_q, turn_q;
	logic stopped_q;

	// Handshake and output drive.
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign heading = heading_q;
	assign speed_now = speed_q;
	assign turn_now = turn_q;
	assign stopped = stopped_q;

	// Command age with saturation and the timeout test.
	logic [24:0] age_sum;
	logic [23:0] age_new;
	logic timeout_hit;
	assign age_sum = {1'b0, age_q} + {5'd0, elapsed_us};
	assign age_new = age_sum[24] ? 24'hFFFFFF : age_sum[23:0];
	assign timeout_hit = age_new > timeout_q;

	// One CORDIC iteration.
	logic signed [33:0] cxs, cys;
	logic [32:0] atan_v;
	assign cxs = cx_q >>> cnt_q[4:0];
	assign cys = cy_q >>> cnt_q[4:0];
	assign atan_v = atan_at(cnt_q[4:0]);

	// Magnitudes for the sign-magnitude products.
	logic [23:0] lin_abs, ang_abs;
	logic [33:0] cos_abs, sin_abs;
	assign lin_abs = lin_q[23] ? (~lin_q + 24'd1) : lin_q;
	assign ang_abs = ang_q[23] ? (~ang_q + 24'd1) : ang_q;
	assign cos_abs = cos_q[33] ? (~cos_q + 34'd1) : cos_q;
	assign sin_abs = sin_q[33] ? (~sin_q + 34'd1) : sin_q;

	// Shift-add multiplier step: one multiplier bit a cycle.
	logic [48:0] mul_sum;
	logic [71:0] mul_next;
	assign mul_sum = {1'b0, mp_q[71:24]} + (mp_q[0] ? {1'b0, ma_q} : 49'd0);
	assign mul_next = {mul_sum, mp_q[23:1]};

	// Restoring divider step by one million: one quotient bit a cycle.
	logic [20:0] rsh;
	logic div_ge;
	logic [47:0] dn_next;
	logic [20:0] rem_next;
	assign rsh = {rem_q[19:0], dn_q[47]};
	assign div_ge = rsh >= US_PER_S;
	assign rem_next = div_ge ? (rsh - US_PER_S) : rsh;
	assign dn_next = {dn_q[46:0], div_ge};

	// Rounded product scalings.
	logic [71:0] t_round, h_round;
	logic [47:0] t_mag;
	logic [31:0] yaw_d;
	assign t_round = mul_next + 72'h20000000;
	assign t_mag = {23'd0, t_round[54:30]};
	assign h_round = mul_next + 72'h800000;
	assign yaw_d = neg_q ? (~h_round[55:24] + 32'd1) : h_round[55:24];

	// Position update with saturation.
	logic signed [33:0] q_signed, pos_old, pos_sum;
	logic signed [31:0] pos_sat;
	assign q_signed = neg_q ? -$signed({1'b0, dn_next[32:0]}) : $signed({1'b0, dn_next[32:0]});
	assign pos_old = (phase_q == PH_XD) ? 34'(x_pos_q) : 34'(y_pos_q);
	assign pos_sum = pos_old + q_signed;
	always_comb begin
		if (pos_sum > 34'sd2147483647) begin
			pos_sat = 32'sh7FFFFFFF;
		end else if (pos_sum < -34'sd2147483648) begin
			pos_sat = 32'sh80000000;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	// Sequencer, datapath and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_XT;
			cnt_q <= '0;
			timeout_q <= TIMEOUT_RESET;
			x_pos_q <= '0;
			y_pos_q <= '0;
			yaw_q <= '0;
			lin_q <= '0;
			ang_q <= '0;
			age_q <= '0;
			timed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!op) begin
							lin_q <= linear_speed;
							ang_q <= angular_speed;
							age_q <= '0;
							timed_q <= 1'b0;
						end else begin
							age_q <= age_new;
							if (timeout_hit) begin
								lin_q <= '0;
								ang_q <= '0;
								timed_q <= 1'b1;
							end
							el_q <= elapsed_us;
							cx_q <= CORDIC_GAIN_Q30;
							cy_q <= '0;
							cz_q <= {3'b000, yaw_q[29:0]};
							cnt_q <= '0;
							state_q <= S_CORDIC;
						end
					end
				end
				S_CORDIC: begin
					if (!cz_q[32]) begin
						cx_q <= cx_q - cys;
						cy_q <= cy_q + cxs;
						cz_q <= cz_q - atan_v;
					end else begin
						cx_q <= cx_q + cys;
						cy_q <= cy_q - cxs;
						cz_q <= cz_q + atan_v;
					end
					if (cnt_q == 6'(STEPS - 1)) begin
						state_q <= S_QUAD;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_QUAD: begin
					case (yaw_q[31:30])
						2'd0: begin cos_q <= cx_q; sin_q <= cy_q; end
						2'd1: begin cos_q <= -cy_q; sin_q <= cx_q; end
						2'd2: begin cos_q <= -cx_q; sin_q <= -cy_q; end
						default: begin cos_q <= cy_q; sin_q <= -cx_q; end
					endcase
					state_q <= S_DIV;
					phase_q <= PH_YD;
					cnt_q <= 6'(DIV_BITS);
				end
				S_MUL: begin
					mp_q <= mul_next;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MUL_BITS - 1)) begin
						cnt_q <= '0;
						case (phase_q)
							PH_XT, PH_YT: begin
								mp_q <= {48'd0, 4'd0, el_q};
								ma_q <= t_mag;
								phase_q <= (phase_q == PH_XT) ? PH_XD : PH_YD;
							end
							PH_XD, PH_YD: begin
								dn_q <= mul_next[47:0] + US_HALF;
								rem_q <= '0;
								state_q <= S_DIV;
							end
							PH_H1: begin
								ma_q <= mul_next[47:0];
								mp_q <= {48'd0, YAW_SCALE};
								phase_q <= PH_H2;
							end
							default: begin
								yaw_q <= yaw_q + yaw_d;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_DIV: begin
					dn_q <= dn_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q + 6'd1;
					// Entry from S_QUAD arrives with the count already full,
					// which starts the x product without a division.
					if (cnt_q >= 6'(DIV_BITS - 1)) begin
						cnt_q <= '0;
						state_q <= S_MUL;
						if (phase_q == PH_XD) begin
							x_pos_q <= pos_sat;
							mp_q <= {48'd0, lin_abs};
							ma_q <= 48'(sin_abs);
							neg_q <= lin_q[23] ^ sin_q[33];
							phase_q <= PH_YT;
						end else if (cnt_q == 6'(DIV_BITS)) begin
							mp_q <= {48'd0, lin_abs};
							ma_q <= 48'(cos_abs);
							neg_q <= lin_q[23] ^ cos_q[33];
							phase_q <= PH_XT;
						end else begin
							y_pos_q <= pos_sat;
							mp_q <= {48'd0, 4'd0, el_q};
							ma_q <= {24'd0, ang_abs};
							neg_q <= ang_q[23];
							phase_q <= PH_H1;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						pos_x_q <= x_pos_q;
						pos_y_q <= y_pos_q;
						heading_q <= yaw_q;
						speed_q <= lin_q;
						turn_q <= ang_q;
						stopped_q <= timed_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A stopped pose always carries zero speeds.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stopped) |-> (speed_now == 24'sd0 && turn_now == 24'sd0))
		else $error("stopped pose with nonzero speed");

	// A command clears the age and the stopped flag.
	a_cmd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !op) |=> (age_q == 24'd0 && !timed_q))
		else $error("command did not restart the watchdog");

	// The CORDIC count stays within its iteration range.
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORDIC) |-> (cnt_q < 6'(STEPS)))
		else $error("CORDIC count out of range");

	// Items are only taken while nothing is in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV) |-> !in_ready)
		else $error("input taken while busy");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for diff_drive_odometry_watchdog_core.
// A pose predictor models the watchdog, the CORDIC and the integration; the DUT's
// pose transfers are checked against it in order. Depends on ddow_pkg and the core.
module tb_top;
	import ddow_pkg::*;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam int STEPS = 16;
	localparam int TICK_CYCLES = STEPS + 260;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [31:0] hd;
		logic signed [23:0] spd;
		logic signed [23:0] trn;
		logic stp;
	} pose_t;

	typedef struct {
		logic o;
		logic [23:0] lin;
		logic [23:0] ang;
		logic [19:0] el;
		logic chk;
		pose_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic signed [23:0] linear_speed = '0;
	logic signed [23:0] angular_speed = '0;
	logic [19:0] elapsed_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x, pos_y;
	logic [31:0] heading;
	logic signed [23:0] speed_now, turn_now;
	logic stopped;

	// Predictor state.
	logic [23:0] m_timeout;
	logic signed [31:0] m_x, m_y;
	logic [31:0] m_yaw;
	logic signed [23:0] m_lin, m_ang;
	logic [23:0] m_age;
	logic m_stop;

	pose_t expected_poses[$];
	int errors = 0;
	int poses_seen = 0;
	int send_idle = 33;
	int recv_idle = 53;
	row_t rows[$];

	always #6 clk = ~clk;

	diff_drive_odometry_watchdog_core #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.linear_speed(linear_speed), .angular_speed(angular_speed),
		.elapsed_us(elapsed_us), .out_valid(out_valid), .out_ready(out_ready),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .speed_now(speed_now),
		.turn_now(turn_now), .stopped(stopped)
	);

	// Rounded division, halves away from zero.
	function automatic longint round_div(input longint num, input longint den);
		longint m;
		m = (num < 0) ? -num : num;
		m = (m + den / 2) / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint atan_table(input int i);
		longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return tbl[i];
	endfunction

	// Cosine and sine of a binary angle in Q2.30.
	task automatic cos_sin(input logic [31:0] ang, output longint c, output longint s);
		longint cx, cy, cz, tx;
		cx = 64'(CORDIC_GAIN_Q30);
		cy = 0;
		cz = longint'(ang[29:0]);
		for (int i = 0; i < STEPS; i++) begin
			tx = cx;
			if (cz >= 0) begin
				cx = cx - (cy >>> i);
				cy = cy + (tx >>> i);
				cz = cz - longint'(atan_table(i));
			end else begin
				cx = cx + (cy >>> i);
				cy = cy - (tx >>> i);
				cz = cz + longint'(atan_table(i));
			end
		end
		case (ang[31:30])
			2'd0: begin c = cx; s = cy; end
			2'd1: begin c = -cy; s = cx; end
			2'd2: begin c = -cx; s = -cy; end
			default: begin c = cy; s = -cx; end
		endcase
	endtask

	// Advance the predictor by one accepted transfer.
	task automatic predict_pose(input logic o, input logic [23:0] lin,
			input logic [23:0] ang, input logic [19:0] el);
		longint c, s, t, d, sum;
		pose_t p;
		if (o == OP_COMMAND) begin
			m_lin = lin;
			m_ang = ang;
			m_age = '0;
			m_stop = 1'b0;
		end else begin
			sum = longint'(m_age) + longint'(el);
			m_age = (sum > 64'd16777215) ? 24'hffffff : sum[23:0];
			if (m_age > m_timeout) begin
				m_lin = '0;
				m_ang = '0;
				m_stop = 1'b1;
			end
			cos_sin(m_yaw, c, s);
			t = round_div(longint'(m_lin) * c, 64'd1 << 30);
			d = round_div(t * longint'(el), 1000000);
			m_x = clamp32(longint'(m_x) + d);
			t = round_div(longint'(m_lin) * s, 64'd1 << 30);
			d = round_div(t * longint'(el), 1000000);
			m_y = clamp32(longint'(m_y) + d);
			d = round_div(longint'(m_ang) * longint'(el) * 174993, 64'd1 << 24);
			m_yaw = m_yaw + d[31:0];
			p = '{m_x, m_y, m_yaw, m_lin, m_ang, m_stop};
			expected_poses.push_back(p);
		end
	endtask

	// One transfer on the input channel; valid stays high into a back-to-back transfer.
	task automatic send_item(input logic o, input logic [23:0] lin,
			input logic [23:0] ang, input logic [19:0] el);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		op <= o;
		linear_speed <= lin;
		angular_speed <= ang;
		elapsed_us <= el;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_pose(o, lin, ang, el);
	endtask

	task automatic drain_poses();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_poses.size() != 0)
			@(posedge clk);
		repeat (TICK_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [23:0] v);
		drain_poses();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_timeout = v;
	endtask

	// Receiver: random stalls, each pose transfer checked against the oldest expectation.
	always @(posedge clk) begin
		pose_t w;
		if (out_valid && out_ready) begin
			poses_seen++;
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected pose x=%0d y=%0d", $time, pos_x, pos_y);
				errors++;
			end else begin
				w = expected_poses.pop_front();
				if (pos_x !== w.px || pos_y !== w.py || heading !== w.hd ||
						speed_now !== w.spd || turn_now !== w.trn || stopped !== w.stp) begin
					$display("%0t: pose mismatch expected x=%0d y=%0d h=%0h s=%0d t=%0d st=%0b",
						$time, w.px, w.py, w.hd, w.spd, w.trn, w.stp);
					$display("%0t:                actual x=%0d y=%0d h=%0h s=%0d t=%0d st=%0b",
						$time, pos_x, pos_y, heading, speed_now, turn_now, stopped);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic add_row(input logic o, input logic [23:0] lin, input logic [23:0] ang,
			input logic [19:0] el);
		row_t r;
		r.o = o; r.lin = lin; r.ang = ang; r.el = el; r.chk = 1'b0; r.want = '0;
		rows.push_back(r);
	endtask

	// Random item: mostly ticks with occasional commands, some wide timing.
	task automatic random_item();
		logic [19:0] el;
		case ($urandom_range(9))
			0: el = 20'($urandom);
			1: el = 20'hfffff;
			2: el = 20'd0;
			default: el = 20'($urandom_range(100000));
		endcase
		if ($urandom_range(4) == 0)
			send_item(OP_COMMAND, 24'($urandom), 24'($urandom), 20'($urandom));
		else
			send_item(OP_TICK, 24'($urandom), 24'($urandom), el);
	endtask

	initial begin
		pose_t p;
		m_timeout = TIMEOUT_RESET;
		m_x = '0; m_y = '0; m_yaw = '0; m_lin = '0; m_ang = '0; m_age = '0; m_stop = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; first row is a tick straight after reset with a known pose.
		add_row(OP_TICK, 24'h0, 24'h0, 20'd0);
		rows[0].chk = 1'b1;
		rows[0].want = '{32'sd0, 32'sd0, 32'd0, 24'sd0, 24'sd0, 1'b0};
		add_row(OP_COMMAND, 24'h7fffff, 24'h7fffff, 20'hfffff);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd100000);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd400000);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd1);
		rows[$].chk = 1'b1;
		add_row(OP_TICK, 24'h0, 24'h0, 20'hfffff);
		add_row(OP_COMMAND, 24'h800000, 24'h800000, 20'd0);
		add_row(OP_TICK, 24'hffffff, 24'hffffff, 20'd250000);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd250000);
		add_row(OP_COMMAND, 24'h010000, 24'h000000, 20'd0);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd50000);
		add_row(OP_COMMAND, 24'h7fffff, 24'h3243f, 20'd0);
		for (int i = 0; i < 6; i++)
			add_row(OP_TICK, 24'h0, 24'h0, 20'd80000);
		add_row(OP_COMMAND, 24'h800000, 24'h7fffff, 20'd0);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd499999);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd1);
		add_row(OP_TICK, 24'h0, 24'h0, 20'd1);
		foreach (rows[i]) begin
			if (rows[i].chk && rows[i].o == OP_TICK && i == 4) begin
				// Age now exceeds the default timeout: speeds forced to zero.
				rows[i].want = '{m_x, m_y, m_yaw, 24'sd0, 24'sd0, 1'b1};
			end
			send_item(rows[i].o, rows[i].lin, rows[i].ang, rows[i].el);
			if (rows[i].chk) begin
				p = expected_poses[$];
				if (p !== rows[i].want) begin
					$display("%0t: directed row %0d expected %h actual prediction %h",
						$time, i, rows[i].want, p);
					errors++;
				end
			end
		end

		// Random phases across timeout settings, including both extremes.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_timeout(24'd0);
				1: write_timeout(24'hffffff);
				2: write_timeout(24'($urandom_range(300000)));
				3: begin
					write_timeout(24'($urandom_range(2000000)));
					send_idle = 53; recv_idle = 33;
				end
				4: write_timeout(24'd150000);
				default: begin
					write_timeout(TIMEOUT_RESET);
					send_idle = 0; recv_idle = 0;
				end
			endcase
			for (int n = 0; n < 125; n++) begin
				random_item();
				if (n == 60)
					drain_poses();
			end
		end

		drain_poses();
		$display("Run covered directed extremes, watchdog timeouts and %0d checked poses",
			poses_seen);
		$display("over six timeout settings with varied input and output stalls.");
		if (errors == 0 && expected_poses.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(64'd12 * 64'd800 * 64'd3000);
		$display("FAILURE");
		$finish;
	end
endmodule
